// File: hw/rtl/wavhp_pkg.sv
// Package for the RIFF/WAVE PCM header parser: chunk identifiers, status and
// sample format codes, the result record type and byte insertion helpers.
// No dependencies.
package wavhp_pkg;

    // Chunk identifiers as they assemble from little-endian bytes.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // Data lengths at or above this limit run until end of file.
    localparam logic [31:0] LEN_LIMIT = 32'h7fff_fffe;
    localparam logic [30:0] LEN_SAT   = 31'h7fff_fffd;

    // Status codes.
    localparam logic [3:0] ST_PARSING   = 4'd0;
    localparam logic [3:0] ST_HDR_DONE  = 4'd1;
    localparam logic [3:0] ST_PAYLOAD   = 4'd2;
    localparam logic [3:0] ST_NOT_WAVE  = 4'd3;
    localparam logic [3:0] ST_FMT_SHORT = 4'd4;
    localparam logic [3:0] ST_NOT_PCM   = 4'd5;
    localparam logic [3:0] ST_NO_CHAN   = 4'd6;
    localparam logic [3:0] ST_BAD_24BIT = 4'd7;
    localparam logic [3:0] ST_BAD_BITS  = 4'd8;
    localparam logic [3:0] ST_TRUNCATED = 4'd9;

    // Sample format codes.
    localparam logic [2:0] FMT_NONE    = 3'd0;
    localparam logic [2:0] FMT_U8      = 3'd1;
    localparam logic [2:0] FMT_S16LE   = 3'd2;
    localparam logic [2:0] FMT_S24_P3  = 3'd3;
    localparam logic [2:0] FMT_S24_IN4 = 3'd4;
    localparam logic [2:0] FMT_S32LE   = 3'd5;

    localparam logic [15:0] TAG_PCM = 16'd1;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  sample_format;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [30:0] data_length;
        logic [7:0]  payload_byte;
        logic        payload_last;
    } result_t;

    // Replace byte number pos of a 32-bit word.
    function automatic logic [31:0] put_byte32(input logic [31:0] word,
                                               input logic [1:0] pos,
                                               input logic [7:0] b);
        logic [31:0] w;
        begin
            w = word;
            w[pos*8 +: 8] = b;
            return w;
        end
    endfunction

    // Replace byte number pos of a 16-bit word.
    function automatic logic [15:0] put_byte16(input logic [15:0] word,
                                               input logic pos,
                                               input logic [7:0] b);
        logic [15:0] w;
        begin
            w = word;
            w[pos*8 +: 8] = b;
            return w;
        end
    endfunction

endpackage

// File: hw/rtl/wav_header_parser_unit.sv
// Top level of the RIFF/WAVE PCM header parser: byte-wide parser state
// machine with a two-entry output stage. Depends on wavhp_pkg.
//
// Usage: the block takes a WAV file one byte per input transfer (in_byte,
// with end_of_file set on the final byte) and returns exactly one result
// transfer per input byte. While the header is parsed, status reports
// parsing progress or a sticky error code; once the data chunk header is
// complete, each audio byte comes out with status payload and the final
// one carries payload_last. The sample format, channel count, sample rate
// and data length fields show what the header declared once known.
// Each result is registered before it is presented; throughput is one byte
// per cycle while in_ready is high. The whole per-byte update (byte capture,
// chunk id and length compares, fmt judgement) is one combinational step
// between the parser state registers and the output register.
// Stalls: the output register is backed by one skid entry, so a byte is
// still taken while a result waits; in_ready drops only when both are full.
// Reset: all parser state clears, the parser waits for the RIFF magic and
// the output stage empties. Errors and completion stay until reset; every
// later byte just returns the sticky status with no payload.
module wav_header_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [2:0]  sample_format,
    output logic [15:0] channel_count,
    output logic [31:0] rate_hz,
    output logic [30:0] data_length,
    output logic [7:0]  payload_byte,
    output logic        payload_last
);
    import wavhp_pkg::*;

    // Parser phases.
    localparam logic [3:0] PH_RIFF  = 4'd0;
    localparam logic [3:0] PH_RSIZE = 4'd1;
    localparam logic [3:0] PH_WAVE  = 4'd2;
    localparam logic [3:0] PH_HDR1  = 4'd3;
    localparam logic [3:0] PH_SKIP1 = 4'd4;
    localparam logic [3:0] PH_PAD1  = 4'd5;
    localparam logic [3:0] PH_FMT   = 4'd6;
    localparam logic [3:0] PH_FPAD  = 4'd7;
    localparam logic [3:0] PH_HDR2  = 4'd8;
    localparam logic [3:0] PH_SKIP2 = 4'd9;
    localparam logic [3:0] PH_PAD2  = 4'd10;
    localparam logic [3:0] PH_PAYC  = 4'd11;
    localparam logic [3:0] PH_PAYO  = 4'd12;
    localparam logic [3:0] PH_DONE  = 4'd13;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] counter_reg, counter_next;
    logic [31:0] chunk_id_reg, chunk_id_next;
    logic [31:0] chunk_len_reg, chunk_len_next;
    logic [15:0] tag_reg, tag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [30:0] left_reg, left_next;
    logic [3:0]  sticky_reg, sticky_next;
    logic [2:0]  fcode_reg, fcode_next;
    logic [30:0] dlen_reg, dlen_next;

    logic        accept;
    logic [31:0] k_inc;
    logic        pay, last;
    result_t     result;

    // Output register plus skid entry.
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    // fmt judgement signals.
    logic [18:0] chan3, chan4, chan5, align_ext;
    logic        per3, per4;
    logic [2:0]  judge_code;
    logic [3:0]  judge_err;

    assign accept   = in_valid && in_ready;
    assign in_ready = !skid_valid_reg;
    assign k_inc    = counter_reg + 32'd1;

    // Field capture inside the fmt chunk.
    always_comb
    begin
        tag_next   = tag_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        align_next = align_reg;
        bits_next  = bits_reg;
        if (phase_reg == PH_FMT)
        begin
            if (counter_reg < 32'd2)
            begin
                tag_next = put_byte16(tag_reg, counter_reg[0], in_byte);
            end
            else if (counter_reg < 32'd4)
            begin
                chan_next = put_byte16(chan_reg, counter_reg[0], in_byte);
            end
            else if (counter_reg < 32'd8)
            begin
                rate_next = put_byte32(rate_reg, counter_reg[1:0], in_byte);
            end
            else if (counter_reg >= 32'd12 && counter_reg < 32'd14)
            begin
                align_next = put_byte16(align_reg, counter_reg[0], in_byte);
            end
            else if (counter_reg >= 32'd14 && counter_reg < 32'd16)
            begin
                bits_next = put_byte16(bits_reg, counter_reg[0], in_byte);
            end
        end
    end

    // For 24-bit samples the bytes per sample are block_align / channels;
    // a quotient of 3 or 4 is found by range compares against 3, 4 and 5
    // times the channel count.
    assign chan3     = {3'b000, chan_next} + {2'b00, chan_next, 1'b0};
    assign chan4     = {1'b0, chan_next, 2'b00};
    assign chan5     = chan4 + {3'b000, chan_next};
    assign align_ext = {3'b000, align_next};
    assign per3      = (align_ext >= chan3) && (align_ext < chan4);
    assign per4      = (align_ext >= chan4) && (align_ext < chan5);

    always_comb
    begin
        judge_code = FMT_NONE;
        judge_err  = ST_PARSING;
        if (tag_next != TAG_PCM)
        begin
            judge_err = ST_NOT_PCM;
        end
        else if (chan_next == 16'd0)
        begin
            judge_err = ST_NO_CHAN;
        end
        else
        begin
            case (bits_next)
                16'd8:  judge_code = FMT_U8;
                16'd16: judge_code = FMT_S16LE;
                16'd24:
                begin
                    if (per3)
                        judge_code = FMT_S24_P3;
                    else if (per4)
                        judge_code = FMT_S24_IN4;
                    else
                        judge_err = ST_BAD_24BIT;
                end
                16'd32: judge_code = FMT_S32LE;
                default: judge_err = ST_BAD_BITS;
            endcase
        end
    end

    // Parser state machine.
    always_comb
    begin
        phase_next     = phase_reg;
        counter_next   = counter_reg;
        chunk_id_next  = chunk_id_reg;
        chunk_len_next = chunk_len_reg;
        left_next      = left_reg;
        sticky_next    = sticky_reg;
        fcode_next     = fcode_reg;
        dlen_next      = dlen_reg;
        pay            = 1'b0;
        last           = 1'b0;

        unique case (phase_reg)
            PH_RIFF, PH_WAVE:
            begin
                chunk_id_next = put_byte32(chunk_id_reg, counter_reg[1:0], in_byte);
                counter_next  = k_inc;
                if (counter_reg >= 32'd3)
                begin
                    if (chunk_id_next != ((phase_reg == PH_RIFF) ? ID_RIFF : ID_WAVE))
                    begin
                        sticky_next = ST_NOT_WAVE;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        phase_next   = (phase_reg == PH_RIFF) ? PH_RSIZE : PH_HDR1;
                        counter_next = 32'd0;
                    end
                end
            end
            PH_RSIZE:
            begin
                counter_next = k_inc;
                if (counter_reg >= 32'd3)
                begin
                    phase_next   = PH_WAVE;
                    counter_next = 32'd0;
                end
            end
            PH_HDR1, PH_HDR2:
            begin
                if (counter_reg < 32'd4)
                    chunk_id_next = put_byte32(chunk_id_reg, counter_reg[1:0], in_byte);
                else
                    chunk_len_next = put_byte32(chunk_len_reg, counter_reg[1:0], in_byte);
                counter_next = k_inc;
                if (counter_reg >= 32'd7)
                begin
                    if (phase_reg == PH_HDR1 && chunk_id_next == ID_FMT)
                    begin
                        if (chunk_len_next < 32'd16)
                        begin
                            sticky_next = ST_FMT_SHORT;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            phase_next   = PH_FMT;
                            counter_next = 32'd0;
                        end
                    end
                    else if (phase_reg == PH_HDR2 && chunk_id_next == ID_DATA)
                    begin
                        sticky_next = ST_HDR_DONE;
                        if (chunk_len_next < LEN_LIMIT)
                        begin
                            dlen_next  = chunk_len_next[30:0];
                            left_next  = chunk_len_next[30:0];
                            phase_next = (chunk_len_next == 32'd0) ? PH_DONE : PH_PAYC;
                        end
                        else
                        begin
                            dlen_next  = LEN_SAT;
                            left_next  = 31'd0;
                            phase_next = PH_PAYO;
                        end
                    end
                    else
                    begin
                        // Skip this chunk; a zero length goes straight to the
                        // next header.
                        counter_next = chunk_len_next;
                        if (chunk_len_next != 32'd0)
                            phase_next = (phase_reg == PH_HDR1) ? PH_SKIP1 : PH_SKIP2;
                        else
                            phase_next = phase_reg;
                    end
                end
            end
            PH_SKIP1, PH_SKIP2:
            begin
                counter_next = counter_reg - 32'd1;
                if (counter_reg == 32'd1)
                begin
                    if (chunk_len_reg[0])
                        phase_next = (phase_reg == PH_SKIP1) ? PH_PAD1 : PH_PAD2;
                    else
                        phase_next = (phase_reg == PH_SKIP1) ? PH_HDR1 : PH_HDR2;
                end
            end
            PH_PAD1:
            begin
                phase_next   = PH_HDR1;
                counter_next = 32'd0;
            end
            PH_PAD2:
            begin
                phase_next   = PH_HDR2;
                counter_next = 32'd0;
            end
            PH_FMT, PH_FPAD:
            begin
                if (phase_reg == PH_FMT)
                    counter_next = k_inc;
                if (phase_reg == PH_FMT && k_inc == chunk_len_reg && chunk_len_reg[0])
                begin
                    phase_next = PH_FPAD;
                end
                else if (phase_reg == PH_FPAD || k_inc == chunk_len_reg)
                begin
                    if (judge_err != ST_PARSING)
                    begin
                        sticky_next = judge_err;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        fcode_next   = judge_code;
                        counter_next = 32'd0;
                        phase_next   = PH_HDR2;
                    end
                end
            end
            PH_PAYC:
            begin
                pay       = 1'b1;
                left_next = left_reg - 31'd1;
                if (left_next == 31'd0 || end_of_file)
                begin
                    last       = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_PAYO:
            begin
                pay = 1'b1;
                if (end_of_file)
                begin
                    last       = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // End of file closes the stream; inside the header it is truncation.
        if (end_of_file)
        begin
            if (sticky_next == ST_PARSING)
                sticky_next = ST_TRUNCATED;
            phase_next = PH_DONE;
        end
    end

    // Result record for the byte now being accepted.
    always_comb
    begin
        result.status        = pay ? ST_PAYLOAD : sticky_next;
        result.sample_format = fcode_next;
        result.channel_count = (fcode_next != FMT_NONE) ? chan_next : 16'd0;
        result.rate_hz       = (fcode_next != FMT_NONE) ? rate_next : 32'd0;
        result.data_length   = dlen_next;
        result.payload_byte  = pay ? in_byte : 8'd0;
        result.payload_last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF;
            counter_reg   <= 32'd0;
            chunk_id_reg  <= 32'd0;
            chunk_len_reg <= 32'd0;
            tag_reg       <= 16'd0;
            chan_reg      <= 16'd0;
            rate_reg      <= 32'd0;
            align_reg     <= 16'd0;
            bits_reg      <= 16'd0;
            left_reg      <= 31'd0;
            sticky_reg    <= ST_PARSING;
            fcode_reg     <= FMT_NONE;
            dlen_reg      <= 31'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            counter_reg   <= counter_next;
            chunk_id_reg  <= chunk_id_next;
            chunk_len_reg <= chunk_len_next;
            tag_reg       <= tag_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            align_reg     <= align_next;
            bits_reg      <= bits_next;
            left_reg      <= left_next;
            sticky_reg    <= sticky_next;
            fcode_reg     <= fcode_next;
            dlen_reg      <= dlen_next;
        end
    end

    // Output stage: a new result goes to the output register when it is free
    // or draining, otherwise to the skid entry, which refills the output
    // register on the next transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_ready)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign sample_format = out_reg.sample_format;
    assign channel_count = out_reg.channel_count;
    assign rate_hz       = out_reg.rate_hz;
    assign data_length   = out_reg.data_length;
    assign payload_byte  = out_reg.payload_byte;
    assign payload_last  = out_reg.payload_last;

endmodule

// File: test/wav_header_parser_unit_tb.sv
// Self-checking testbench for wav_header_parser_unit: feeds one WAV file byte by byte
// and checks every result transfer against a cycle-free model of the header parser.
// Depends on wavhp_pkg and wav_header_parser_unit.
`timescale 1ns / 1ps

module tb;
    import wavhp_pkg::*;

    // The run is cut off here if the results stop coming. The slowest legal run is
    // about 1700 bytes, each with a long sender gap and a long receiver stall, plus
    // the one long hold-off, which still stays well below this limit.
    localparam int CYCLE_LIMIT = 600_000;
    // Result count at which the receiver stops taking results for a long stretch.
    localparam int HOLD_AT = 20;
    localparam int HOLD_CYCLES = 300;

    // Where the parser stands within the file.
    typedef enum logic [3:0] {
        P_RIFF_ID, P_RIFF_SIZE, P_WAVE_ID,
        P_SEEK_FMT, P_SKIP_PRE, P_PAD_PRE,
        P_FMT_BODY, P_FMT_PAD,
        P_SEEK_DATA, P_SKIP_POST, P_PAD_POST,
        P_PAY_COUNTED, P_PAY_OPEN, P_FINISHED
    } parse_phase_t;

    // Header defect planted in the generated file, if any.
    typedef enum int {
        FLAW_NONE, FLAW_MAGIC, FLAW_FMT_SHORT, FLAW_TAG,
        FLAW_NO_CHAN, FLAW_BAD24, FLAW_BITS, FLAW_TRUNC
    } flaw_t;

    // How the data chunk is declared and how the payload ends.
    typedef enum int {
        DATA_COUNTED, DATA_EARLY_EOF, DATA_OPEN, DATA_EMPTY
    } data_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
    } file_byte_t;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
        logic [3:0] status;
    } directed_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        end_of_file = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;
    logic [2:0]  sample_format;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [30:0] data_length;
    logic [7:0]  payload_byte;
    logic        payload_last;

    wav_header_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sample_format (sample_format),
        .channel_count (channel_count),
        .rate_hz       (rate_hz),
        .data_length   (data_length),
        .payload_byte  (payload_byte),
        .payload_last  (payload_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Results predicted for accepted bytes, oldest first.
    result_t pending_results [$];
    // Bytes of the generated file still to be offered.
    file_byte_t file_q [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  send_calm = 1'b0;
    bit  drain_calm = 1'b0;

    // Parser state as the model keeps it.
    parse_phase_t ph;
    logic [31:0]  byte_idx;
    logic [31:0]  word_id;
    logic [31:0]  word_len;
    logic [15:0]  fmt_tag;
    logic [15:0]  fmt_chans;
    logic [31:0]  fmt_rate;
    logic [15:0]  fmt_align;
    logic [15:0]  fmt_bits;
    logic [30:0]  pay_left;
    logic [3:0]   sticky_code;
    logic [2:0]   fmt_code;
    logic [30:0]  dlen_shown;

    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic latch_error(input logic [3:0] code);
        sticky_code = code;
        ph = P_FINISHED;
    endtask

    // Runs once the whole fmt chunk, pad included, has been taken. The checks go
    // in order: tag, then channels, then bit depth.
    task automatic judge_fmt();
        logic [15:0] per;
        logic [2:0]  code;
        code = FMT_NONE;
        if (fmt_tag != TAG_PCM)
            latch_error(ST_NOT_PCM);
        else if (fmt_chans == 16'd0)
            latch_error(ST_NO_CHAN);
        else
        begin
            per = fmt_align / fmt_chans;
            case (fmt_bits)
                16'd8:  code = FMT_U8;
                16'd16: code = FMT_S16LE;
                16'd24:
                begin
                    if (per == 16'd3)
                        code = FMT_S24_P3;
                    else if (per == 16'd4)
                        code = FMT_S24_IN4;
                    else
                        latch_error(ST_BAD_24BIT);
                end
                16'd32: code = FMT_S32LE;
                default: latch_error(ST_BAD_BITS);
            endcase
            if (code != FMT_NONE)
            begin
                fmt_code = code;
                byte_idx = 32'd0;
                ph = P_SEEK_DATA;
            end
        end
    endtask

    // Advances the parser by one accepted byte and gives the result it causes.
    task automatic parse_header_byte(input logic [7:0] b, input logic eof,
                                     output result_t r);
        logic        pay;
        logic        last;
        logic [31:0] k;
        pay = 1'b0;
        last = 1'b0;
        k = byte_idx;
        case (ph)
            P_RIFF_ID, P_WAVE_ID:
            begin
                word_id[8*k[1:0] +: 8] = b;
                byte_idx = k + 32'd1;
                if (k >= 32'd3)
                begin
                    if (word_id != ((ph == P_RIFF_ID) ? ID_RIFF : ID_WAVE))
                        latch_error(ST_NOT_WAVE);
                    else
                    begin
                        ph = (ph == P_RIFF_ID) ? P_RIFF_SIZE : P_SEEK_FMT;
                        byte_idx = 32'd0;
                    end
                end
            end
            P_RIFF_SIZE:
            begin
                byte_idx = k + 32'd1;
                if (k >= 32'd3)
                begin
                    ph = P_WAVE_ID;
                    byte_idx = 32'd0;
                end
            end
            P_SEEK_FMT, P_SEEK_DATA:
            begin
                if (k < 32'd4)
                    word_id[8*k[1:0] +: 8] = b;
                else
                    word_len[8*k[1:0] +: 8] = b;
                byte_idx = k + 32'd1;
                if (k >= 32'd7)
                begin
                    if (ph == P_SEEK_FMT)
                    begin
                        if (word_id == ID_FMT)
                        begin
                            if (word_len < 32'd16)
                                latch_error(ST_FMT_SHORT);
                            else
                            begin
                                ph = P_FMT_BODY;
                                byte_idx = 32'd0;
                            end
                        end
                        else
                        begin
                            // Any other chunk is skipped; an empty one has no body.
                            byte_idx = word_len;
                            ph = (word_len != 32'd0) ? P_SKIP_PRE : P_SEEK_FMT;
                        end
                    end
                    else if (word_id == ID_DATA)
                    begin
                        sticky_code = ST_HDR_DONE;
                        if (word_len < LEN_LIMIT)
                        begin
                            dlen_shown = word_len[30:0];
                            pay_left = word_len[30:0];
                            ph = (word_len == 32'd0) ? P_FINISHED : P_PAY_COUNTED;
                        end
                        else
                        begin
                            // Too long to count: the payload runs to end of file.
                            dlen_shown = LEN_SAT;
                            pay_left = 31'd0;
                            ph = P_PAY_OPEN;
                        end
                    end
                    else
                    begin
                        byte_idx = word_len;
                        ph = (word_len != 32'd0) ? P_SKIP_POST : P_SEEK_DATA;
                    end
                end
            end
            P_SKIP_PRE, P_SKIP_POST:
            begin
                byte_idx = byte_idx - 32'd1;
                if (byte_idx == 32'd0)
                begin
                    if (ph == P_SKIP_PRE)
                        ph = word_len[0] ? P_PAD_PRE : P_SEEK_FMT;
                    else
                        ph = word_len[0] ? P_PAD_POST : P_SEEK_DATA;
                end
            end
            P_PAD_PRE:
            begin
                ph = P_SEEK_FMT;
                byte_idx = 32'd0;
            end
            P_PAD_POST:
            begin
                ph = P_SEEK_DATA;
                byte_idx = 32'd0;
            end
            P_FMT_BODY:
            begin
                if (k < 32'd2)
                    fmt_tag[8*k[0] +: 8] = b;
                else if (k < 32'd4)
                    fmt_chans[8*k[0] +: 8] = b;
                else if (k < 32'd8)
                    fmt_rate[8*k[1:0] +: 8] = b;
                else if (k >= 32'd12 && k < 32'd14)
                    fmt_align[8*k[0] +: 8] = b;
                else if (k >= 32'd14 && k < 32'd16)
                    fmt_bits[8*k[0] +: 8] = b;
                byte_idx = k + 32'd1;
                if (k + 32'd1 == word_len)
                begin
                    if (word_len[0])
                        ph = P_FMT_PAD;
                    else
                        judge_fmt();
                end
            end
            P_FMT_PAD: judge_fmt();
            P_PAY_COUNTED:
            begin
                pay = 1'b1;
                pay_left = pay_left - 31'd1;
                if (pay_left == 31'd0 || eof)
                begin
                    last = 1'b1;
                    ph = P_FINISHED;
                end
            end
            P_PAY_OPEN:
            begin
                pay = 1'b1;
                if (eof)
                begin
                    last = 1'b1;
                    ph = P_FINISHED;
                end
            end
            default: ph = P_FINISHED;
        endcase

        // End of file inside the header is a truncation unless this very byte
        // already settled the status.
        if (eof)
        begin
            if (sticky_code == ST_PARSING)
                sticky_code = ST_TRUNCATED;
            ph = P_FINISHED;
        end

        r.status        = pay ? ST_PAYLOAD : sticky_code;
        r.sample_format = fmt_code;
        r.channel_count = (fmt_code != FMT_NONE) ? fmt_chans : 16'd0;
        r.rate_hz       = (fmt_code != FMT_NONE) ? fmt_rate : 32'd0;
        r.data_length   = dlen_shown;
        r.payload_byte  = pay ? b : 8'd0;
        r.payload_last  = last;
    endtask

    // Offers one byte and returns at the edge where its transfer takes place.
    // A typed status replaces the predicted result; the model still advances.
    task automatic offer_byte(input logic [7:0] b, input logic eof,
                              input logic typed, input logic [3:0] want_status);
        int      gap;
        result_t want;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_header_byte(b, eof, want);
        if (typed)
        begin
            want = '0;
            want.status = want_status;
        end
        pending_results.push_back(want);
    endtask

    task automatic put_word(input logic [31:0] v, input int n);
        int i;
        for (i = 0; i < n; i++)
            file_q.push_back('{value: v[8*i +: 8], eof: 1'b0});
    endtask

    // A chunk the parser must skip. Ahead of fmt a data chunk is just another
    // chunk, and after fmt so is a second fmt chunk.
    task automatic put_junk(input bit ahead_of_fmt);
        logic [31:0] id;
        int          len;
        int          i;
        id = $urandom;
        if (ahead_of_fmt && $urandom_range(0, 3) == 0)
            id = ID_DATA;
        else if (!ahead_of_fmt && $urandom_range(0, 3) == 0)
            id = ID_FMT;
        if (ahead_of_fmt && id == ID_FMT)
            id = id ^ 32'h1;
        if (!ahead_of_fmt && id == ID_DATA)
            id = id ^ 32'h1;
        len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
        put_word(id, 4);
        put_word(len, 4);
        for (i = 0; i < len + (len % 2); i++)
            put_word($urandom_range(0, 255), 1);
    endtask

    // Builds the rest of the file after the RIFF size. Most files are well formed
    // with random content; the rest carry one header defect.
    task automatic build_file();
        flaw_t       flaw;
        data_mode_t  mode;
        int          r;
        int          len;
        int          n;
        int          cut;
        int          i;
        int          per;
        logic [15:0] tag;
        logic [15:0] ch;
        logic [15:0] align;
        logic [15:0] bps;
        logic [31:0] dlen;

        flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE : flaw_t'($urandom_range(1, 7));
        put_word((flaw == FLAW_MAGIC) ? (ID_WAVE ^ (32'h1 << $urandom_range(0, 31)))
                                      : ID_WAVE, 4);
        repeat ($urandom_range(0, 3)) put_junk(1'b1);

        if (flaw == FLAW_FMT_SHORT)
            len = $urandom_range(0, 15);
        else
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : 16;
        put_word(ID_FMT, 4);
        put_word(len, 4);
        if (flaw == FLAW_FMT_SHORT)
            return;

        tag = TAG_PCM;
        if (flaw == FLAW_TAG)
        begin
            tag = 16'($urandom_range(0, 65535));
            if (tag == TAG_PCM)
                tag = 16'd0;
        end
        bps = 16'(8 * $urandom_range(1, 4));
        if (flaw == FLAW_BAD24)
            bps = 16'd24;
        if (flaw == FLAW_BITS)
        begin
            bps = 16'($urandom_range(0, 65535));
            if (bps == 16'd8 || bps == 16'd16 || bps == 16'd24 || bps == 16'd32)
                bps = bps + 16'd1;
        end
        ch = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8));
        if (bps == 16'd24)
            ch = 16'($urandom_range(1, 8));
        if (flaw == FLAW_NO_CHAN)
            ch = 16'd0;
        align = 16'($urandom_range(0, 65535));
        if (bps == 16'd24 && ch != 16'd0)
        begin
            // Block align over channels picks packed or padded 24-bit samples;
            // a remainder below one channel must not change the quotient.
            per = $urandom_range(3, 4);
            if (flaw == FLAW_BAD24)
            begin
                per = $urandom_range(0, 6);
                if (per > 2)
                    per = per + 2;
            end
            align = 16'(int'(ch) * per + $urandom_range(0, int'(ch) - 1));
        end
        put_word(32'(tag), 2);
        put_word(32'(ch), 2);
        put_word($urandom, 4);
        put_word($urandom, 4);
        put_word(32'(align), 2);
        put_word(32'(bps), 2);
        for (i = 16; i < len + (len % 2); i++)
            put_word($urandom_range(0, 255), 1);
        if (flaw == FLAW_TAG || flaw == FLAW_NO_CHAN || flaw == FLAW_BAD24 ||
            flaw == FLAW_BITS)
            return;

        repeat ($urandom_range(0, 2)) put_junk(1'b0);

        r = $urandom_range(0, 99);
        if (r < 60)
            mode = DATA_COUNTED;
        else if (r < 78)
            mode = DATA_EARLY_EOF;
        else if (r < 94)
            mode = DATA_OPEN;
        else
            mode = DATA_EMPTY;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(1100, 1350);
        case (mode)
            DATA_COUNTED:   dlen = n;
            DATA_EARLY_EOF: dlen = n + $urandom_range(1, 1000);
            DATA_OPEN:
            begin
                r = $urandom_range(0, 2);
                dlen = (r == 0) ? LEN_LIMIT :
                       (r == 1) ? 32'hFFFF_FFFF : $urandom_range(32'hFFFF_FFFF, LEN_LIMIT);
            end
            default:        dlen = 32'd0;
        endcase
        put_word(ID_DATA, 4);
        put_word(dlen, 4);

        if (flaw == FLAW_TRUNC)
        begin
            // End of file somewhere before the data header is complete.
            cut = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > cut)
                void'(file_q.pop_back());
            file_q[file_q.size() - 1].eof = 1'b1;
            return;
        end

        if (mode == DATA_EMPTY)
        begin
            file_q[file_q.size() - 1].eof = 1'($urandom_range(0, 1));
            return;
        end
        for (i = 0; i < n; i++)
            put_word($urandom_range(0, 255), 1);
        // A counted payload ends by itself; end of file on its last byte is optional.
        if (mode != DATA_COUNTED || $urandom_range(0, 1) == 1)
            file_q[file_q.size() - 1].eof = 1'b1;
    endtask

    // Stimulus: reset, the directed opening of the file, a pause until every
    // result has come back, then the generated remainder and some trailing bytes.
    initial
    begin : stimulus
        directed_row_t rows [8];
        file_byte_t    fb;
        int            sent;
        int            i;

        // RIFF magic, then the RIFF size with both byte extremes (never checked).
        rows = '{
            '{8'h52, 1'b0, ST_PARSING}, '{8'h49, 1'b0, ST_PARSING},
            '{8'h46, 1'b0, ST_PARSING}, '{8'h46, 1'b0, ST_PARSING},
            '{8'hFF, 1'b0, ST_PARSING}, '{8'h00, 1'b0, ST_PARSING},
            '{8'hFF, 1'b0, ST_PARSING}, '{8'h00, 1'b0, ST_PARSING}
        };

        ph = P_RIFF_ID;
        byte_idx = '0;
        word_id = '0;
        word_len = '0;
        fmt_tag = '0;
        fmt_chans = '0;
        fmt_rate = '0;
        fmt_align = '0;
        fmt_bits = '0;
        pay_left = '0;
        sticky_code = ST_PARSING;
        fmt_code = FMT_NONE;
        dlen_shown = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 8; i++)
            offer_byte(rows[i].value, rows[i].eof, 1'b1, rows[i].status);

        // The sender goes quiet until the block has handed back every result.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);

        build_file();
        // Whatever follows the end of the file must be ignored by the block; a
        // short file gets enough trailing bytes to keep the run at its usual length.
        if (file_q.size() < 1422)
            repeat (1442 - file_q.size()) put_word($urandom_range(0, 255), 1);
        else
            repeat ($urandom_range(4, 24)) put_word($urandom_range(0, 255), 1);
        foreach (file_q[j])
            if ($urandom_range(0, 3) == 0 && j >= file_q.size() - 24)
                file_q[j].eof = 1'b1;
        file_q[file_q.size() - 1].eof = 1'b1;

        sent = 0;
        while (file_q.size() != 0)
        begin
            // Now and then a stretch of back-to-back transfers.
            if (sent % 100 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            fb = file_q.pop_front();
            offer_byte(fb.value, fb.eof, 1'b0, ST_PARSING);
            sent++;
        end
        in_valid <= 1'b0;

        // Drain, then give a late stray result the time to show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, calm stretches, and one long hold-off so that the
    // output stage fills and the block has to drop in_ready.
    initial
    begin : drain
        result_t got;
        result_t want;
        int      stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 199) == 0)
                drain_calm = !drain_calm;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap(drain_calm);
            end
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {status, sample_format, channel_count, rate_hz,
                       data_length, payload_byte, payload_last};
                results_seen++;
                if (results_seen == HOLD_AT)
                    stall_left = HOLD_CYCLES;
                if (pending_results.size() == 0)
                    log_mismatch($sformatf("result %0d arrived with none expected",
                                           results_seen));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        log_mismatch($sformatf("result %0d status %0d, want %0d",
                                               results_seen, got.status, want.status));
                    if (got.sample_format !== want.sample_format)
                        log_mismatch($sformatf("result %0d sample_format %0d, want %0d",
                                               results_seen, got.sample_format,
                                               want.sample_format));
                    if (got.channel_count !== want.channel_count)
                        log_mismatch($sformatf("result %0d channel_count %0d, want %0d",
                                               results_seen, got.channel_count,
                                               want.channel_count));
                    if (got.rate_hz !== want.rate_hz)
                        log_mismatch($sformatf("result %0d rate_hz %0d, want %0d",
                                               results_seen, got.rate_hz,
                                               want.rate_hz));
                    if (got.data_length !== want.data_length)
                        log_mismatch($sformatf("result %0d data_length %0d, want %0d",
                                               results_seen, got.data_length,
                                               want.data_length));
                    if (got.payload_byte !== want.payload_byte)
                        log_mismatch($sformatf("result %0d payload_byte %0h, want %0h",
                                               results_seen, got.payload_byte,
                                               want.payload_byte));
                    if (got.payload_last !== want.payload_last)
                        log_mismatch($sformatf("result %0d payload_last %0b, want %0b",
                                               results_seen, got.payload_last,
                                               want.payload_last));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
